@@ rtl/ihpq_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed heap priority queue package
// Shared types, codes and default sizes for the heap block.
// ----------------------------------------------------------------------------
package ihpq_pkg;

  localparam int unsigned HeapDepthDef = 64;
  localparam int unsigned IdBitsDef    = 16;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_PEEK   = 3'd2;
  localparam logic [2:0] ACT_UPDATE = 3'd3;
  localparam logic [2:0] ACT_REMOVE = 3'd4;
  localparam logic [2:0] ACT_QUERY  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] entry_id;
    logic [15:0] entry_score;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_id;
    logic [15:0] result_score;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } out_item_t;

endpackage

@@ rtl/ihpq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ihpq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/indexed_max_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Indexed max-heap priority queue
// Binary max-heap of (identifier, score) entries held in one RAM.
// ----------------------------------------------------------------------------
// One transaction at a time runs through a small sequencer around a single
// RAM port pair, one heap access per cycle. Push rises one level per parent
// read and compare. Pop and peek read the root; pop then sinks, reading up to
// two children per level. Update, remove and query first search linearly from
// slot zero, one slot per cycle; update and remove then sift. The input stays
// stalled from the accepted transaction until its result is handed to the
// output register, so a new transaction is taken only after the last is done.
// A finished result waits in the output register, and the next result waits
// for it.
module indexed_max_heap_priority_queue
  import ihpq_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = HeapDepthDef,
  parameter int unsigned ID_BITS    = IdBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned KW = AW + 2;
  localparam int unsigned EW = ID_BITS + 16;
  localparam int unsigned NB = (ID_BITS < 16) ? ID_BITS : 16;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_TOP, S_LAST, S_SRCH, S_REMW,
    S_RISE, S_RISEW, S_SINK, S_SINKL, S_SINKR, S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d, k_q, k_d;
  logic [AW-1:0]     pos_q, pos_d, chk_k_q, chk_k_d;
  logic              chk_v_q, chk_v_d;
  logic [2:0]        act_q, act_d;
  logic [ID_BITS-1:0] id_q, id_d, e_id_q, e_id_d, c_id_q, c_id_d;
  logic [15:0]       score_q, score_d, e_score_q, e_score_d, c_score_q, c_score_d;
  logic              c_sel_q, c_sel_d, moved_q, moved_d, sink_after_q, sink_after_d;
  logic [15:0]       res_id_q, res_id_d, res_score_q, res_score_d;
  logic [1:0]        res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [EW-1:0]     wdata, rdata;
  logic [ID_BITS-1:0] rd_id, id_in;
  logic [15:0]       rd_score, rd_id16, best_score;
  logic [AW-1:0]     parent;
  logic [KW-1:0]     lchild, rchild, cnt_k;

  ihpq_ram #(.Width(EW), .Depth(HEAP_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_id    = rdata[EW-1:16];
  assign rd_score = rdata[15:0];
  assign parent   = AW'((pos_q - AW'(1)) >> 1);
  assign lchild   = {1'b0, pos_q, 1'b1};
  assign rchild   = {1'b0, pos_q, 1'b0} + KW'(2);
  assign cnt_k    = KW'(cnt_q);
  assign best_score = c_sel_q ? c_score_q : e_score_q;

  always_comb begin
    id_in   = '0;
    rd_id16 = '0;
    for (int b = 0; b < NB; b++) begin
      id_in[b]   = in_data_i.entry_id[b];
      rd_id16[b] = rd_id[b];
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    pos_d        = pos_q;
    chk_k_d      = chk_k_q;
    chk_v_d      = 1'b0;
    act_d        = act_q;
    id_d         = id_q;
    score_d      = score_q;
    e_id_d       = e_id_q;
    e_score_d    = e_score_q;
    c_id_d       = c_id_q;
    c_score_d    = c_score_q;
    c_sel_d      = c_sel_q;
    moved_d      = moved_q;
    sink_after_d = sink_after_q;
    res_id_d     = res_id_q;
    res_score_d  = res_score_q;
    res_st_d     = res_st_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = pos_q;
    raddr        = '0;
    wdata        = {e_id_q, e_score_q};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d        = in_data_i.action;
          id_d         = id_in;
          score_d      = in_data_i.entry_score;
          res_id_d     = '0;
          res_score_d  = '0;
          res_st_d     = ST_OK;
          moved_d      = 1'b0;
          sink_after_d = 1'b0;
          k_d          = '0;
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        case (act_q)
          ACT_PUSH: begin
            if (cnt_q == CW'(HEAP_DEPTH)) begin
              res_st_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              e_id_d    = id_q;
              e_score_d = score_q;
              pos_d     = AW'(cnt_q);
              cnt_d     = cnt_q + CW'(1);
              state_d   = S_RISE;
            end
          end
          ACT_POP, ACT_PEEK: begin
            if (cnt_q == '0) begin
              res_st_d = ST_EMPTY;
              state_d  = S_FIN;
            end else begin
              re      = 1'b1;
              raddr   = '0;
              state_d = S_TOP;
            end
          end
          ACT_UPDATE, ACT_REMOVE, ACT_QUERY: state_d = S_SRCH;
          default: state_d = S_FIN;
        endcase
      end
      S_TOP: begin
        res_id_d    = rd_id16;
        res_score_d = rd_score;
        if (act_q == ACT_PEEK) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_d = S_FIN;
          end else begin
            re      = 1'b1;
            raddr   = AW'(cnt_q - CW'(1));
            pos_d   = '0;
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        e_id_d    = rd_id;
        e_score_d = rd_score;
        state_d   = S_SINK;
      end
      S_SRCH: begin
        if (chk_v_q && rd_id == id_q) begin
          pos_d = chk_k_q;
          case (act_q)
            ACT_QUERY: begin
              res_id_d    = rd_id16;
              res_score_d = rd_score;
              state_d     = S_FIN;
            end
            ACT_UPDATE: begin
              e_id_d    = rd_id;
              e_score_d = score_q;
              state_d   = (score_q > rd_score) ? S_RISE : S_SINK;
            end
            ACT_REMOVE: begin
              cnt_d = cnt_q - CW'(1);
              if (CW'(chk_k_q) == cnt_q - CW'(1)) begin
                state_d = S_FIN;
              end else begin
                re           = 1'b1;
                raddr        = AW'(cnt_q - CW'(1));
                sink_after_d = 1'b1;
                state_d      = S_REMW;
              end
            end
            default: state_d = S_FIN;
          endcase
        end else if (k_q < cnt_q) begin
          re      = 1'b1;
          raddr   = AW'(k_q);
          chk_v_d = 1'b1;
          chk_k_d = AW'(k_q);
          k_d     = k_q + CW'(1);
        end else begin
          res_st_d = ST_NOTFOUND;
          state_d  = S_FIN;
        end
      end
      S_REMW: begin
        e_id_d    = rd_id;
        e_score_d = rd_score;
        state_d   = S_RISE;
      end
      S_RISE: begin
        if (pos_q != '0) begin
          re      = 1'b1;
          raddr   = parent;
          state_d = S_RISEW;
        end else if (sink_after_q && !moved_q) begin
          state_d = S_SINK;
        end else begin
          we      = 1'b1;
          state_d = S_FIN;
        end
      end
      S_RISEW: begin
        if (rd_score < e_score_q) begin
          we      = 1'b1;
          wdata   = rdata;
          pos_d   = parent;
          moved_d = 1'b1;
          state_d = S_RISE;
        end else if (sink_after_q && !moved_q) begin
          state_d = S_SINK;
        end else begin
          we      = 1'b1;
          state_d = S_FIN;
        end
      end
      S_SINK: begin
        if (lchild >= cnt_k) begin
          we      = 1'b1;
          state_d = S_FIN;
        end else begin
          re      = 1'b1;
          raddr   = lchild[AW-1:0];
          state_d = S_SINKL;
        end
      end
      S_SINKL: begin
        c_id_d    = rd_id;
        c_score_d = rd_score;
        c_sel_d   = e_score_q < rd_score;
        if (rchild < cnt_k) begin
          re      = 1'b1;
          raddr   = rchild[AW-1:0];
          state_d = S_SINKR;
        end else if (e_score_q < rd_score) begin
          we      = 1'b1;
          wdata   = rdata;
          pos_d   = lchild[AW-1:0];
          state_d = S_SINK;
        end else begin
          we      = 1'b1;
          state_d = S_FIN;
        end
      end
      S_SINKR: begin
        if (best_score < rd_score) begin
          we      = 1'b1;
          wdata   = rdata;
          pos_d   = rchild[AW-1:0];
          state_d = S_SINK;
        end else if (c_sel_q) begin
          we      = 1'b1;
          wdata   = {c_id_q, c_score_q};
          pos_d   = lchild[AW-1:0];
          state_d = S_SINK;
        end else begin
          we      = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.result_id    = res_id_q;
          out_d.result_score = res_score_q;
          out_d.status       = res_st_q;
          out_d.entry_count  = 7'(cnt_q);
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      k_q          <= '0;
      pos_q        <= '0;
      chk_k_q      <= '0;
      chk_v_q      <= 1'b0;
      act_q        <= '0;
      id_q         <= '0;
      score_q      <= '0;
      e_id_q       <= '0;
      e_score_q    <= '0;
      c_id_q       <= '0;
      c_score_q    <= '0;
      c_sel_q      <= 1'b0;
      moved_q      <= 1'b0;
      sink_after_q <= 1'b0;
      res_id_q     <= '0;
      res_score_q  <= '0;
      res_st_q     <= ST_OK;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      k_q          <= k_d;
      pos_q        <= pos_d;
      chk_k_q      <= chk_k_d;
      chk_v_q      <= chk_v_d;
      act_q        <= act_d;
      id_q         <= id_d;
      score_q      <= score_d;
      e_id_q       <= e_id_d;
      e_score_q    <= e_score_d;
      c_id_q       <= c_id_d;
      c_score_q    <= c_score_d;
      c_sel_q      <= c_sel_d;
      moved_q      <= moved_d;
      sink_after_q <= sink_after_d;
      res_id_q     <= res_id_d;
      res_score_q  <= res_score_d;
      res_st_q     <= res_st_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/sv/indexed_max_heap_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed max-heap priority queue testbench
// Drives directed and random actions with random idling on both channels and
// checks each result against an in-bench heap model or a typed-in result.
// ----------------------------------------------------------------------------
module indexed_max_heap_priority_queue_tb;
  import ihpq_pkg::*;

  localparam int unsigned Depth      = 64;
  localparam int unsigned RandItems  = 1040;
  localparam int unsigned WatchLimit = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  indexed_max_heap_priority_queue dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow heap.
  logic [15:0] heap_ids [Depth];
  logic [15:0] heap_scores [Depth];
  int unsigned heap_count;

  out_item_t   pending_results[$];
  int unsigned error_count;
  int unsigned idle_send_pct;
  int unsigned stall_recv_pct;
  int unsigned quiet_cycles = 0;
  bit          stim_done;

  // Directed table: stimulus, a flag for a typed-in result, and that result.
  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t result;
  } vector_t;

  function automatic out_item_t mk_result(logic [15:0] id, logic [15:0] sc,
                                          logic [1:0] st, logic [6:0] cnt);
    out_item_t r;
    r.result_id = id;
    r.result_score = sc;
    r.status = st;
    r.entry_count = cnt;
    return r;
  endfunction

  function automatic void swap_heap(int unsigned a, int unsigned b);
    logic [15:0] ti, ts;
    ti = heap_ids[a];
    ts = heap_scores[a];
    heap_ids[a] = heap_ids[b];
    heap_scores[a] = heap_scores[b];
    heap_ids[b] = ti;
    heap_scores[b] = ts;
  endfunction

  function automatic void sift_up(int unsigned pos);
    int unsigned parent;
    while (pos > 0 && pos < heap_count) begin
      parent = (pos - 1) / 2;
      if (heap_scores[parent] < heap_scores[pos]) begin
        swap_heap(parent, pos);
        pos = parent;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void sift_down(int unsigned pos);
    int unsigned top;
    while (pos < heap_count) begin
      top = pos;
      if (2 * pos + 1 < heap_count && heap_scores[top] < heap_scores[2 * pos + 1])
        top = 2 * pos + 1;
      if (2 * pos + 2 < heap_count && heap_scores[top] < heap_scores[2 * pos + 2])
        top = 2 * pos + 2;
      if (top == pos) break;
      swap_heap(pos, top);
      pos = top;
    end
  endfunction

  function automatic int find_entry(logic [15:0] id);
    for (int unsigned k = 0; k < heap_count; k++)
      if (heap_ids[k] == id) return k;
    return -1;
  endfunction

  function automatic out_item_t heap_action(in_item_t it);
    out_item_t r;
    int        pos;
    logic [15:0] old;
    r = '0;
    case (it.action)
      ACT_PUSH: begin
        if (heap_count >= Depth) begin
          r.status = ST_FULL;
        end else begin
          heap_ids[heap_count] = it.entry_id;
          heap_scores[heap_count] = it.entry_score;
          heap_count++;
          sift_up(heap_count - 1);
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (heap_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_id = heap_ids[0];
          r.result_score = heap_scores[0];
          if (it.action == ACT_POP) begin
            heap_count--;
            heap_ids[0] = heap_ids[heap_count];
            heap_scores[0] = heap_scores[heap_count];
            if (heap_count > 0) sift_down(0);
          end
        end
      end
      ACT_UPDATE: begin
        pos = find_entry(it.entry_id);
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          old = heap_scores[pos];
          heap_scores[pos] = it.entry_score;
          if (it.entry_score > old) sift_up(pos);
          else sift_down(pos);
        end
      end
      ACT_REMOVE: begin
        pos = find_entry(it.entry_id);
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          heap_count--;
          heap_ids[pos] = heap_ids[heap_count];
          heap_scores[pos] = heap_scores[heap_count];
          if (pos < heap_count) begin
            sift_up(pos);
            sift_down(pos);
          end
        end
      end
      ACT_QUERY: begin
        pos = find_entry(it.entry_id);
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.result_id = heap_ids[pos];
          r.result_score = heap_scores[pos];
        end
      end
      default: ;
    endcase
    r.entry_count = heap_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // Drive one transaction and hold it until accepted.
  task automatic send_item(in_item_t it, bit fixed, out_item_t want);
    out_item_t pred;
    while (idle_send_pct != 0 && $urandom_range(99) < idle_send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = heap_action(it);
    pending_results = {pending_results, (fixed ? want : pred)};
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    int unsigned pick;
    int unsigned held;
    pick = $urandom_range(99);
    held = heap_count;
    if (held < 8) pick = pick % 50;
    else if (held > 56) pick = 25 + pick % 75;
    it.entry_score = 16'($urandom);
    if ($urandom_range(3) == 0) it.entry_score = 16'($urandom_range(3));
    // Identifiers mostly come from a small pool so lookups hit and duplicates occur.
    it.entry_id = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    if (pick < 40) it.action = ACT_PUSH;
    else if (pick < 52) it.action = ACT_POP;
    else if (pick < 58) it.action = ACT_PEEK;
    else if (pick < 72) it.action = ACT_UPDATE;
    else if (pick < 84) it.action = ACT_REMOVE;
    else if (pick < 96) it.action = ACT_QUERY;
    else it.action = 3'($urandom_range(6, 7));
    if (it.action inside {ACT_UPDATE, ACT_REMOVE, ACT_QUERY} && held > 0
        && $urandom_range(3) != 0)
      it.entry_id = heap_ids[$urandom_range(held - 1)];
    return it;
  endfunction

  // Result checking and receiver stalls.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transaction", 32'(out_data_o), 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.result_id !== want.result_id)
            report_mismatch("result_id", out_data_o.result_id, want.result_id);
          if (out_data_o.result_score !== want.result_score)
            report_mismatch("result_score", out_data_o.result_score, want.result_score);
          if (out_data_o.status !== want.status)
            report_mismatch("status", out_data_o.status, want.status);
          if (out_data_o.entry_count !== want.entry_count)
            report_mismatch("entry_count", out_data_o.entry_count, want.entry_count);
        end
      end
      out_stall_i <= (stall_recv_pct != 0) && ($urandom_range(99) < stall_recv_pct);
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else if (pending_results.size() != 0 || !stim_done)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    vector_t table_v[$];
    vector_t v;
    error_count = 0;
    stim_done = 1'b0;
    idle_send_pct = 0;
    stall_recv_pct = 0;
    heap_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty heap cases, then extremes, duplicates, ties and odd codes.
    v.fixed = 1; v.item = '{ACT_POP, 16'h0, 16'h0};
    v.result = mk_result(0, 0, ST_EMPTY, 0); table_v = {table_v, v};
    v.item = '{ACT_PEEK, 16'hFFFF, 16'hFFFF}; table_v = {table_v, v};
    v.item = '{ACT_UPDATE, 16'h1234, 16'h0001};
    v.result = mk_result(0, 0, ST_NOTFOUND, 0); table_v = {table_v, v};
    v.item = '{ACT_REMOVE, 16'hFFFF, 16'h0}; table_v = {table_v, v};
    v.item = '{ACT_QUERY, 16'h0, 16'h0}; table_v = {table_v, v};
    v.item = '{3'd7, 16'hFFFF, 16'hFFFF};
    v.result = mk_result(0, 0, ST_OK, 0); table_v = {table_v, v};
    v.item = '{ACT_PUSH, 16'hFFFF, 16'hFFFF};
    v.result = mk_result(0, 0, ST_OK, 1); table_v = {table_v, v};
    v.item = '{ACT_PEEK, 16'h0, 16'h0};
    v.result = mk_result(16'hFFFF, 16'hFFFF, ST_OK, 1); table_v = {table_v, v};
    v.fixed = 0;
    v.item = '{ACT_PUSH, 16'h0000, 16'h0000}; table_v = {table_v, v};
    v.item = '{ACT_PUSH, 16'h0005, 16'h0100}; table_v = {table_v, v};
    v.item = '{ACT_PUSH, 16'h0005, 16'h0100}; table_v = {table_v, v};
    v.item = '{ACT_PUSH, 16'h0007, 16'h0100}; table_v = {table_v, v};
    v.item = '{ACT_QUERY, 16'h0005, 16'h0}; table_v = {table_v, v};
    v.item = '{ACT_UPDATE, 16'h0000, 16'hFFFF}; table_v = {table_v, v};
    v.item = '{ACT_UPDATE, 16'h0005, 16'h0100}; table_v = {table_v, v};
    v.item = '{ACT_UPDATE, 16'hFFFF, 16'h0000}; table_v = {table_v, v};
    v.item = '{ACT_REMOVE, 16'h0005, 16'h0}; table_v = {table_v, v};
    v.item = '{ACT_REMOVE, 16'h0007, 16'h0}; table_v = {table_v, v};
    v.item = '{ACT_POP, 16'h0, 16'h0}; table_v = {table_v, v};
    v.item = '{3'd6, 16'hAAAA, 16'h5555}; table_v = {table_v, v};
    v.item = '{ACT_QUERY, 16'hFFFF, 16'h0}; table_v = {table_v, v};
    foreach (table_v[i]) send_item(table_v[i].item, table_v[i].fixed, table_v[i].result);

    // Fill to capacity, then overflow once.
    while (heap_count < Depth) send_item('{ACT_PUSH, 16'($urandom), 16'($urandom)}, 0, '0);
    send_item('{ACT_PUSH, 16'h5A5A, 16'hA5A5}, 1, mk_result(0, 0, ST_FULL, 7'd64));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_send_pct = 0;  stall_recv_pct = 0;  end
        1: begin idle_send_pct = 47; stall_recv_pct = 0;  end
        2: begin idle_send_pct = 0;  stall_recv_pct = 47; end
        default: begin idle_send_pct = 34; stall_recv_pct = 34; end
      endcase
      for (int k = 0; k < RandItems / 4; k++) send_item(rand_item(), 0, '0);
    end
    // Drain the heap with pops so deep sinks are covered.
    while (heap_count > 0) send_item('{ACT_POP, 16'h0, 16'h0}, 0, '0);
    in_valid_i <= 1'b0;

    stim_done = 1'b1;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
